>>> hdl/gsa_pkg.sv
// Shared types and constants of the generational slot allocator.
package gsa_pkg;

	localparam int SLOT_W = 10;
	localparam int GEN_W  = 32;
	localparam int CNT_W  = 11;

	localparam logic REQ_ALLOC  = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOT_OCC = 2'd2
	} gsa_status_t;

	// Commands from the controller to the datapath, one per request phase.
	typedef struct packed {
		logic accept;
		logic look;
		logic commit;
	} gsa_cmd_t;

endpackage

>>> hdl/gsa_if.sv
// Request and response channel interfaces of the slot allocator.
interface gsa_req_if import gsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output req_type, output slot, input ready);
	modport sink (input valid, input req_type, input slot, output ready);
endinterface

interface gsa_rsp_if import gsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot_out;
	logic [GEN_W-1:0]  generation;
	logic [SLOT_W-1:0] dense_index;
	logic              moved;
	logic [SLOT_W-1:0] moved_from;
	logic [CNT_W-1:0]  live_count;

	modport source (output valid, output status, output slot_out, output generation,
		output dense_index, output moved, output moved_from, output live_count,
		input ready);
	modport sink (input valid, input status, input slot_out, input generation,
		input dense_index, input moved, input moved_from, input live_count,
		output ready);
endinterface

>>> hdl/generational_slot_allocator_dense_unit.sv
// Top level of the generational slot allocator with a packed dense map.
//
//   channel  modport  transfer carries
//   req      sink     req_type, slot
//   rsp      source   status, slot_out, generation, dense_index, moved,
//                     moved_from, live_count
//
// Each request passes through the accept, lookup and commit phases in turn: the
// stack pop feeds a generation read, and a remove reads slot-to-dense and then
// dense-to-slot before the memories are written. The result enters the output
// register at the commit, and the next request can transfer once the sequencer
// has returned to idle.
// A new request transfers while a result still waits in the output register.
// A stalled output holds the commit phase, and with it the memory writes.
// Reset is immediate; no clearing pass runs over the memories.
module generational_slot_allocator_dense_unit import gsa_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input logic     clk,
	input logic     arst_n,
	gsa_req_if.sink   req,
	gsa_rsp_if.source rsp
);

	gsa_cmd_t cmd;

	gsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	gsa_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_req_type (req.req_type),
		.in_slot     (req.slot),
		.status      (rsp.status),
		.slot_out    (rsp.slot_out),
		.generation  (rsp.generation),
		.dense_index (rsp.dense_index),
		.moved       (rsp.moved),
		.moved_from  (rsp.moved_from),
		.live_count  (rsp.live_count)
	);

endmodule

>>> hdl/gsa_ctrl.sv
// Request sequencer of the slot allocator: accept, lookup and commit phases.
module gsa_ctrl import gsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output gsa_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOK   = 3'b010,
		S_COMMIT = 3'b100
	} gsa_state_t;

	gsa_state_t state_q;
	gsa_state_t state_d;
	logic       out_valid_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.look   = (state_q == S_LOOK);
	// The commit waits until the output register is free or being emptied.
	assign cmd.commit = (state_q == S_COMMIT) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_LOOK)
		else $error("accepted request did not enter lookup");

	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && state_q == S_IDLE)
		else $error("commit did not present a result");

	a_blocked_commit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && out_valid_q && !out_ready) |=>
		(state_q == S_COMMIT && out_valid_q))
		else $error("blocked commit did not hold");

endmodule

>>> hdl/gsa_datapath.sv
// Slot allocator datapath: free stack, generation/occupancy and dense map memories.
module gsa_datapath import gsa_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gsa_cmd_t          cmd,
	input  logic              in_req_type,
	input  logic [SLOT_W-1:0] in_slot,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot_out,
	output logic [GEN_W-1:0]  generation,
	output logic [SLOT_W-1:0] dense_index,
	output logic              moved,
	output logic [SLOT_W-1:0] moved_from,
	output logic [CNT_W-1:0]  live_count
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Occupied flag sits on top of the generation in one word.
	logic [IW-1:0]    stk_mem [SLOTS];
	logic [GEN_W:0]   gen_mem [SLOTS];
	logic [IW-1:0]    s2d_mem [SLOTS];
	logic [IW-1:0]    d2s_mem [SLOTS];

	logic [CW-1:0]     free_top_q;
	logic [CW-1:0]     low_mark_q;
	logic [CW-1:0]     live_q;
	logic              req_rm_q;
	logic [SLOT_W-1:0] s_q;
	logic              fresh_q;
	logic [IW-1:0]     slot_q;
	logic [IW-1:0]     stk_rd_q;
	logic [GEN_W:0]    gen_rd_q;
	logic [IW-1:0]     s2d_rd_q;
	logic [IW-1:0]     d2s_rd_q;

	logic [1:0]        status_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic [GEN_W-1:0]  generation_q;
	logic [SLOT_W-1:0] dense_index_q;
	logic              moved_q;
	logic [SLOT_W-1:0] moved_from_q;
	logic [CNT_W-1:0]  live_count_q;

	logic [IW-1:0]    in_idx;
	logic [IW-1:0]    alloc_slot;
	logic             gen_re;
	logic [IW-1:0]    gen_raddr;
	logic             pool_full;
	logic             rm_bad;
	logic             alloc_ok;
	logic             rm_ok;
	logic [IW-1:0]    hole;
	logic [IW-1:0]    last;
	logic             do_move;
	logic [IW-1:0]    live_idx;
	logic [GEN_W-1:0] alloc_gen;
	logic [GEN_W-1:0] next_gen;

	logic             gen_we;
	logic [GEN_W:0]   gen_wdata;
	logic             s2d_we;
	logic [IW-1:0]    s2d_waddr;
	logic [IW-1:0]    s2d_wdata;
	logic             d2s_we;
	logic [IW-1:0]    d2s_waddr;
	logic [IW-1:0]    d2s_wdata;

	assign in_idx   = IW'(in_slot);
	assign live_idx = IW'(live_q);
	assign last     = IW'(live_q - CW'(1));

	// Stack entries below the low-water mark were never pushed and hold no valid
	// entry, so such a pop hands out the next never-used slot.
	assign alloc_slot = fresh_q ? IW'(CW'(SLOTS) - free_top_q) : stk_rd_q;

	assign gen_re    = (cmd.accept && in_req_type == REQ_REMOVE) ||
		(cmd.look && !req_rm_q);
	assign gen_raddr = cmd.accept ? in_idx : alloc_slot;

	assign pool_full = (free_top_q == '0);
	// Slots at or above SLOTS minus the low-water mark were never allocated.
	assign rm_bad    = (32'(s_q) >= 32'(SLOTS)) ||
		(CW'(slot_q) >= (CW'(SLOTS) - low_mark_q)) || !gen_rd_q[GEN_W];
	assign alloc_ok  = !req_rm_q && !pool_full;
	assign rm_ok     = req_rm_q && !rm_bad;
	assign hole      = s2d_rd_q;
	assign do_move   = (hole != last);
	assign alloc_gen = fresh_q ? GEN_W'(1) : gen_rd_q[GEN_W-1:0];
	assign next_gen  = gen_rd_q[GEN_W-1:0] + GEN_W'(1);

	always_comb begin
		gen_we    = cmd.commit && (alloc_ok || rm_ok);
		gen_wdata = rm_ok ? {1'b0, next_gen} : {1'b1, alloc_gen};
		s2d_we    = cmd.commit && (alloc_ok || (rm_ok && do_move));
		s2d_waddr = rm_ok ? d2s_rd_q : slot_q;
		s2d_wdata = rm_ok ? hole : live_idx;
		d2s_we    = s2d_we;
		d2s_waddr = rm_ok ? hole : live_idx;
		d2s_wdata = rm_ok ? d2s_rd_q : slot_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && rm_ok) stk_mem[IW'(free_top_q)] <= slot_q;
		if (cmd.accept) stk_rd_q <= stk_mem[IW'(free_top_q - CW'(1))];
	end

	always_ff @(posedge clk) begin
		if (gen_we) gen_mem[slot_q] <= gen_wdata;
		if (gen_re) gen_rd_q <= gen_mem[gen_raddr];
	end

	always_ff @(posedge clk) begin
		if (s2d_we) s2d_mem[s2d_waddr] <= s2d_wdata;
		if (cmd.accept) s2d_rd_q <= s2d_mem[in_idx];
	end

	always_ff @(posedge clk) begin
		if (d2s_we) d2s_mem[d2s_waddr] <= d2s_wdata;
		if (cmd.look) d2s_rd_q <= d2s_mem[last];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_rm_q <= in_req_type;
			s_q      <= in_slot;
			fresh_q  <= (free_top_q == low_mark_q);
		end
		if (cmd.look) begin
			slot_q <= req_rm_q ? IW'(s_q) : alloc_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q <= CW'(SLOTS);
			low_mark_q <= CW'(SLOTS);
			live_q     <= '0;
		end else if (cmd.commit) begin
			if (alloc_ok) begin
				free_top_q <= free_top_q - CW'(1);
				live_q     <= live_q + CW'(1);
				if (fresh_q) low_mark_q <= low_mark_q - CW'(1);
			end else if (rm_ok) begin
				free_top_q <= free_top_q + CW'(1);
				live_q     <= live_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q      <= ST_OK;
			slot_out_q    <= '0;
			generation_q  <= '0;
			dense_index_q <= '0;
			moved_q       <= 1'b0;
			moved_from_q  <= '0;
			live_count_q  <= CNT_W'(live_q);
			if (!req_rm_q) begin
				if (pool_full) begin
					status_q <= ST_FULL;
				end else begin
					slot_out_q    <= SLOT_W'(slot_q);
					generation_q  <= alloc_gen;
					dense_index_q <= SLOT_W'(live_idx);
					live_count_q  <= CNT_W'(live_q + CW'(1));
				end
			end else begin
				slot_out_q <= s_q;
				if (rm_bad) begin
					status_q <= ST_NOT_OCC;
				end else begin
					generation_q  <= next_gen;
					dense_index_q <= SLOT_W'(hole);
					moved_q       <= do_move;
					moved_from_q  <= do_move ? SLOT_W'(last) : '0;
					live_count_q  <= CNT_W'(live_q - CW'(1));
				end
			end
		end
	end

	assign status      = status_q;
	assign slot_out    = slot_out_q;
	assign generation  = generation_q;
	assign dense_index = dense_index_q;
	assign moved       = moved_q;
	assign moved_from  = moved_from_q;
	assign live_count  = live_count_q;

	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(live_q) + 32'(free_top_q)) == 32'(SLOTS))
		else $error("live count and free stack depth disagree");

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		low_mark_q <= free_top_q)
		else $error("free stack top fell below its low-water mark");

	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && alloc_ok) |=> live_q == $past(live_q) + CW'(1))
		else $error("allocate did not grow the live count");

endmodule
